FILE: hdl/lprt_pkg.sv
// ----------------------------------------------------------------------------
// LRU tracker package
// Shared sizes, operation and status codes, and the per-cell command type
// for the least-recently-used page tracker.
// ----------------------------------------------------------------------------
package lprt_pkg;

    localparam int CAPACITY    = 64;
    localparam int MAX_VICTIMS = 8;
    localparam int PAGE_BITS   = 40;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int RANK_W = 3;
    localparam int VCNT_W = $clog2(MAX_VICTIMS + 1);
    localparam int VK_W   = (VCNT_W > RANK_W) ? VCNT_W : RANK_W;
    localparam int CMP_W  = (CNT_W > VK_W) ? CNT_W : VK_W;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int IN_TDATA_W   = ((PAGE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((PAGE_BITS + RANK_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = STATUS_W + 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ACCESS  = 2'd0;
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
    localparam logic [OP_W-1:0] OP_EVICTED = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] STS_INSERTED    = 3'd1;
    localparam logic [STATUS_W-1:0] STS_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] STS_REMOVED     = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NOT_TRACKED = 3'd4;
    localparam logic [STATUS_W-1:0] STS_VICTIM      = 3'd5;

    // Cell commands.
    localparam logic [1:0] CELL_HOLD     = 2'd0;
    localparam logic [1:0] CELL_SHIFT_DN = 2'd1;
    localparam logic [1:0] CELL_SHIFT_UP = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic       capture;
    } cell_ctrl_t;

endpackage

FILE: hdl/lprt_cell.sv
// ----------------------------------------------------------------------------
// LRU tracker cell
// One position of the recency stack: holds a page and its valid bit, takes
// the entry of either neighbor on command, and registers a page match.
// ----------------------------------------------------------------------------
module lprt_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lprt_pkg::cell_ctrl_t          ctrl,
    input  logic [lprt_pkg::PAGE_BITS-1:0] cmp_page,
    input  logic [lprt_pkg::PAGE_BITS-1:0] prev_page,
    input  logic                          prev_valid,
    input  logic [lprt_pkg::PAGE_BITS-1:0] next_page,
    input  logic                          next_valid,
    output logic [lprt_pkg::PAGE_BITS-1:0] page,
    output logic                          valid,
    output logic                          match
);

    logic [lprt_pkg::PAGE_BITS-1:0] page_reg;
    logic [lprt_pkg::PAGE_BITS-1:0] page_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic                          match_reg;
    logic                          match_next;

    always_comb
    begin
        page_next  = page_reg;
        valid_next = valid_reg;
        case (ctrl.cmd)
            lprt_pkg::CELL_SHIFT_DN:
            begin
                page_next  = prev_page;
                valid_next = prev_valid;
            end
            lprt_pkg::CELL_SHIFT_UP:
            begin
                page_next  = next_page;
                valid_next = next_valid;
            end
            default:
            begin
                page_next  = page_reg;
                valid_next = valid_reg;
            end
        endcase
        match_next = ctrl.capture ? (valid_reg && (page_reg == cmp_page)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    assign page  = page_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

FILE: hdl/lprt_enc.sv
// ----------------------------------------------------------------------------
// LRU tracker match encoder
// Turns the one-hot match row of the cells into a registered hit flag and
// the position of the matching cell.
// ----------------------------------------------------------------------------
module lprt_enc (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [lprt_pkg::CAPACITY-1:0]  match,
    output logic                           hit,
    output logic [lprt_pkg::IDX_W-1:0]     idx
);

    logic                       hit_reg;
    logic                       hit_next;
    logic [lprt_pkg::IDX_W-1:0] idx_reg;
    logic [lprt_pkg::IDX_W-1:0] idx_next;

    // Pages in the stack are distinct, so at most one bit is set and each
    // index bit is an OR over the positions that carry that bit.
    always_comb
    begin
        idx_next = '0;
        for (int b = 0; b < lprt_pkg::IDX_W; b++)
        begin
            for (int i = 0; i < lprt_pkg::CAPACITY; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    idx_next[b] = idx_next[b] | match[i];
                end
            end
        end
        hit_next = |match;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            hit_reg <= hit_next;
            idx_reg <= idx_next;
        end
    end

    assign hit = hit_reg;
    assign idx = idx_reg;

endmodule

FILE: hdl/lru_page_replacement_tracker_unit.sv
// ----------------------------------------------------------------------------
// LRU page replacement tracker
// Keeps up to CAPACITY pages in a shifting recency stack and answers page
// accesses, eviction notices and victim requests.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake               Contents
//  s_axis    in   s_axis_tvalid/tready    tuser: operation; tdata: page
//  m_axis    out  m_axis_tvalid/tready    tuser: status, victim_valid;
//                                         tdata: suggested page, victim_rank;
//                                         tlast: last
//
// An access or an eviction notice passes these steps in order: the accepting
// edge registers the per-cell page compares, the match state encodes the
// matching position, and the apply state shifts the stack and loads the
// result, waiting while the output is stalled. The next request is accepted
// once the apply state has returned to idle. A victim request rotates the
// whole stack once past the tail cell, which is where victims are read,
// oldest first: after the match it makes CAPACITY shifts, and only once it
// has returned to idle is the next request accepted. The input is ready
// only while no request is in progress. A stalled output freezes the
// rotation, and the result register lets the next request be accepted
// while the previous result still waits. Reset clears the valid bits and
// count at once, so the block is ready right after reset.
//
// Cell 0 holds the most recent page; while idle, valid cells form a prefix
// of the row, so the entry at position count-1 is the least recently used.
module lru_page_replacement_tracker_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [PAGE_BITS-1:0] page, rest zero
    input  logic [lprt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] operation
    input  logic [lprt_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [PAGE_BITS-1:0] suggested page, [PAGE_BITS+2:PAGE_BITS] victim_rank, rest zero
    output logic [lprt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [2:0] status, [3] victim_valid
    output logic [lprt_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int CAP = lprt_pkg::CAPACITY;
    localparam int PW  = lprt_pkg::PAGE_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MATCH  = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;
    localparam logic [1:0] ST_ROTATE = 2'd3;

    logic [1:0] st_reg;
    logic [1:0] st_next;

    logic [lprt_pkg::OP_W-1:0]  op_reg;
    logic [PW-1:0]              req_page_reg;
    logic [lprt_pkg::CNT_W-1:0] cnt_reg;
    logic [lprt_pkg::CNT_W-1:0] cnt_next;
    logic [lprt_pkg::CNT_W-1:0] step_reg;
    logic [lprt_pkg::CNT_W-1:0] step_next;
    logic [lprt_pkg::VK_W-1:0]  k_reg;
    logic [lprt_pkg::VK_W-1:0]  k_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [lprt_pkg::STATUS_W-1:0] out_status_reg;
    logic [lprt_pkg::STATUS_W-1:0] out_status_next;
    logic [PW-1:0]                 out_page_reg;
    logic [PW-1:0]                 out_page_next;
    logic                          out_vvalid_reg;
    logic                          out_vvalid_next;
    logic [lprt_pkg::RANK_W-1:0]   out_rank_reg;
    logic [lprt_pkg::RANK_W-1:0]   out_rank_next;
    logic                          out_last_reg;
    logic                          out_last_next;

    lprt_pkg::cell_ctrl_t cell_ctrl [CAP];
    logic [PW-1:0]        cell_page [CAP];
    logic [CAP-1:0]       cell_valid;
    logic [CAP-1:0]       cell_match;

    logic                       enc_hit;
    logic [lprt_pkg::IDX_W-1:0] enc_idx;

    logic                       accept;
    logic                       out_free;
    logic                       is_full;
    logic [lprt_pkg::VK_W-1:0]  n_victims;
    logic                       apply_go;
    logic                       rot_shift;
    logic [PW-1:0]              head_page;
    logic                       head_valid;

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign is_full       = (cnt_reg == lprt_pkg::CNT_W'(CAP));

    // Number of victims listed: the smaller of the count and the list limit.
    always_comb
    begin
        if (lprt_pkg::CMP_W'(cnt_reg) < lprt_pkg::CMP_W'(lprt_pkg::MAX_VICTIMS))
        begin
            n_victims = lprt_pkg::VK_W'(cnt_reg);
        end
        else
        begin
            n_victims = lprt_pkg::VK_W'(lprt_pkg::MAX_VICTIMS);
        end
    end

    // During rotation the tail wraps into the head; otherwise the head is
    // loaded with the requested page.
    assign head_page  = (st_reg == ST_ROTATE) ? cell_page[CAP-1] : req_page_reg;
    assign head_valid = (st_reg == ST_ROTATE) ? cell_valid[CAP-1] : 1'b1;

    // Sequencer and result register.
    always_comb
    begin
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        k_next          = k_reg;
        apply_go        = 1'b0;
        rot_shift       = 1'b0;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;
        out_vvalid_next = out_vvalid_reg;
        out_rank_next   = out_rank_reg;
        out_last_next   = out_last_reg;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (accept && (s_axis_tuser == lprt_pkg::OP_ACCESS ||
                               s_axis_tuser == lprt_pkg::OP_REQUEST ||
                               s_axis_tuser == lprt_pkg::OP_EVICTED))
                begin
                    st_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                st_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (op_reg == lprt_pkg::OP_REQUEST && cnt_reg != '0)
                begin
                    st_next   = ST_ROTATE;
                    step_next = '0;
                    k_next    = '0;
                end
                else if (out_free)
                begin
                    apply_go        = 1'b1;
                    st_next         = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_page_next   = '0;
                    out_vvalid_next = 1'b0;
                    out_rank_next   = '0;
                    out_last_next   = 1'b1;
                    case (op_reg)
                        lprt_pkg::OP_ACCESS:
                        begin
                            if (enc_hit)
                            begin
                                out_status_next = lprt_pkg::STS_HIT;
                            end
                            else if (is_full)
                            begin
                                out_status_next = lprt_pkg::STS_FULL;
                            end
                            else
                            begin
                                out_status_next = lprt_pkg::STS_INSERTED;
                                cnt_next        = cnt_reg + 1'b1;
                            end
                        end
                        lprt_pkg::OP_EVICTED:
                        begin
                            if (enc_hit)
                            begin
                                out_status_next = lprt_pkg::STS_REMOVED;
                                cnt_next        = cnt_reg - 1'b1;
                            end
                            else
                            begin
                                out_status_next = lprt_pkg::STS_NOT_TRACKED;
                            end
                        end
                        default:
                        begin
                            // Victim request on an empty tracker.
                            out_status_next = lprt_pkg::STS_VICTIM;
                        end
                    endcase
                end
            end
            ST_ROTATE:
            begin
                if (step_reg == lprt_pkg::CNT_W'(CAP))
                begin
                    st_next = ST_IDLE;
                end
                else if (cell_valid[CAP-1] && k_reg < n_victims)
                begin
                    if (out_free)
                    begin
                        rot_shift       = 1'b1;
                        step_next       = step_reg + 1'b1;
                        k_next          = k_reg + 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = lprt_pkg::STS_VICTIM;
                        out_page_next   = cell_page[CAP-1];
                        out_vvalid_next = 1'b1;
                        out_rank_next   = k_reg[lprt_pkg::RANK_W-1:0];
                        out_last_next   = (k_reg + 1'b1 == n_victims);
                    end
                end
                else
                begin
                    rot_shift = 1'b1;
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Per-cell commands. An access hit at position p shifts cells 0..p down
    // and reloads the head; an insert or a rotation shifts the whole row;
    // a removal pulls cells at and above the hit one place toward the head.
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            cell_ctrl[i].capture = accept;
            cell_ctrl[i].cmd     = lprt_pkg::CELL_HOLD;
            if (rot_shift)
            begin
                cell_ctrl[i].cmd = lprt_pkg::CELL_SHIFT_DN;
            end
            else if (apply_go && op_reg == lprt_pkg::OP_ACCESS)
            begin
                if (enc_hit)
                begin
                    if (lprt_pkg::IDX_W'(i) <= enc_idx)
                    begin
                        cell_ctrl[i].cmd = lprt_pkg::CELL_SHIFT_DN;
                    end
                end
                else if (!is_full)
                begin
                    cell_ctrl[i].cmd = lprt_pkg::CELL_SHIFT_DN;
                end
            end
            else if (apply_go && op_reg == lprt_pkg::OP_EVICTED)
            begin
                if (enc_hit && lprt_pkg::IDX_W'(i) >= enc_idx)
                begin
                    cell_ctrl[i].cmd = lprt_pkg::CELL_SHIFT_UP;
                end
            end
        end
    end

    for (genvar g = 0; g < CAP; g++)
    begin : g_cell
        logic [PW-1:0] prev_page;
        logic          prev_valid;
        logic [PW-1:0] next_page;
        logic          next_valid;

        if (g == 0)
        begin : g_head
            assign prev_page  = head_page;
            assign prev_valid = head_valid;
        end
        else
        begin : g_body
            assign prev_page  = cell_page[g-1];
            assign prev_valid = cell_valid[g-1];
        end

        if (g == CAP - 1)
        begin : g_tail
            assign next_page  = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_inner
            assign next_page  = cell_page[g+1];
            assign next_valid = cell_valid[g+1];
        end

        lprt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl[g]),
            .cmp_page   (s_axis_tdata[PW-1:0]),
            .prev_page  (prev_page),
            .prev_valid (prev_valid),
            .next_page  (next_page),
            .next_valid (next_valid),
            .page       (cell_page[g]),
            .valid      (cell_valid[g]),
            .match      (cell_match[g])
        );
    end

    lprt_enc u_enc (
        .clk   (clk),
        .rst_n (rst_n),
        .match (cell_match),
        .hit   (enc_hit),
        .idx   (enc_idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            k_reg         <= '0;
            op_reg        <= lprt_pkg::OP_ACCESS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                op_reg <= s_axis_tuser;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_page_reg <= s_axis_tdata[PW-1:0];
        end
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_vvalid_reg <= out_vvalid_next;
        out_rank_reg   <= out_rank_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = lprt_pkg::OUT_TDATA_W'({out_rank_reg, out_page_reg});
    assign m_axis_tuser  = {out_vvalid_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= lprt_pkg::CNT_W'(CAP))
        else $error("tracked count above capacity");

    // The valid bits of the row always agree with the count.
    a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(cnt_reg))
        else $error("valid cells disagree with tracked count");

    // A full rotation has listed every victim it owed.
    a_victims_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_ROTATE && step_reg == lprt_pkg::CNT_W'(CAP)) |-> k_reg == n_victims)
        else $error("rotation ended with victims missing");

    // While idle, valid entries are packed toward the head of the row.
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE) |-> ((cell_valid & (cell_valid + 1'b1)) == '0))
        else $error("valid cells do not form a prefix");

endmodule

FILE: tb/sv/lru_page_replacement_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// LRU page replacement tracker testbench
// Drives page accesses, eviction notices, victim requests and unused
// operation codes into the tracker, predicts every result from a recency list
// kept alongside the block, and compares each result field by field.
// ----------------------------------------------------------------------------
module lru_page_replacement_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The one operation code the block must ignore without any result.
    localparam logic [lprt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int POOL_SIZE      = 96;
    localparam int TIMEOUT_CYCLES = 400000;
    // A victim request keeps the block busy for a full stack rotation, so the
    // settling time at the end covers that plus some margin.
    localparam int SETTLE_CYCLES  = lprt_pkg::CAPACITY + 16;

    typedef logic [lprt_pkg::PAGE_BITS-1:0] page_t;

    typedef struct packed {
        logic [lprt_pkg::STATUS_W-1:0] status;
        page_t                         cand_page;
        logic                          victim_valid;
        logic [lprt_pkg::RANK_W-1:0]   victim_rank;
        logic                          last;
    } outcome_t;

    // ------------------------------------------------------------------------
    // Recency predictor and result checker.
    // The tracked pages are held as a list ordered by recency: entry 0 is the
    // most recently used page and the tail is the least recently used one.
    // This ordering alone decides every result the block produces.
    // ------------------------------------------------------------------------
    class lru_order_checker;
        page_t    mru_order[$];
        outcome_t pending_outcomes[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        function void push_outcome(logic [lprt_pkg::STATUS_W-1:0] st, page_t vp,
                                   logic vv, logic [lprt_pkg::RANK_W-1:0] vr,
                                   logic lst);
            outcome_t o;
            o.status       = st;
            o.cand_page    = vp;
            o.victim_valid = vv;
            o.victim_rank  = vr;
            o.last         = lst;
            pending_outcomes.push_back(o);
        endfunction

        // Called for every accepted request; appends the results it causes.
        function void note_request(logic [lprt_pkg::OP_W-1:0] op, page_t page);
            int hit_at;
            int n;
            hit_at = -1;
            foreach (mru_order[i])
                if (hit_at < 0 && mru_order[i] == page)
                    hit_at = i;
            case (op)
                lprt_pkg::OP_ACCESS:
                begin
                    if (hit_at >= 0)
                    begin
                        mru_order.delete(hit_at);
                        mru_order.insert(0, page);
                        push_outcome(lprt_pkg::STS_HIT, '0, 1'b0, '0, 1'b1);
                    end
                    else if (mru_order.size() >= lprt_pkg::CAPACITY)
                    begin
                        push_outcome(lprt_pkg::STS_FULL, '0, 1'b0, '0, 1'b1);
                    end
                    else
                    begin
                        mru_order.insert(0, page);
                        push_outcome(lprt_pkg::STS_INSERTED, '0, 1'b0, '0, 1'b1);
                    end
                end
                lprt_pkg::OP_REQUEST:
                begin
                    if (mru_order.size() == 0)
                    begin
                        push_outcome(lprt_pkg::STS_VICTIM, '0, 1'b0, '0, 1'b1);
                    end
                    else
                    begin
                        n = (mru_order.size() < lprt_pkg::MAX_VICTIMS) ?
                            mru_order.size() : lprt_pkg::MAX_VICTIMS;
                        for (int k = 0; k < n; k++)
                            push_outcome(lprt_pkg::STS_VICTIM,
                                         mru_order[mru_order.size() - 1 - k],
                                         1'b1, lprt_pkg::RANK_W'(k), k == n - 1);
                    end
                end
                lprt_pkg::OP_EVICTED:
                begin
                    if (hit_at >= 0)
                    begin
                        mru_order.delete(hit_at);
                        push_outcome(lprt_pkg::STS_REMOVED, '0, 1'b0, '0, 1'b1);
                    end
                    else
                    begin
                        push_outcome(lprt_pkg::STS_NOT_TRACKED, '0, 1'b0, '0, 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want != got)
                flag($sformatf("%s expected %h, got %h", field, want, got));
        endfunction

        // Called for every accepted result; compares it with the oldest
        // outstanding prediction.
        function void check_result(outcome_t got);
            outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                flag($sformatf("unexpected result: status %0d page %h valid %0d rank %0d last %0d",
                               got.status, got.cand_page, got.victim_valid,
                               got.victim_rank, got.last));
                return;
            end
            want = pending_outcomes.pop_front();
            compare_field("status",       64'(want.status),       64'(got.status));
            compare_field("suggested page", 64'(want.cand_page),  64'(got.cand_page));
            compare_field("victim_valid", 64'(want.victim_valid), 64'(got.victim_valid));
            compare_field("victim_rank",  64'(want.victim_rank),  64'(got.victim_rank));
            compare_field("last",         64'(want.last),         64'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports. All inputs start at known values.
    // ------------------------------------------------------------------------
    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [lprt_pkg::IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [lprt_pkg::OP_W-1:0]         s_axis_tuser  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [lprt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [lprt_pkg::OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                              m_axis_tlast;

    int unsigned             cycle_count    = 0;
    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;
    page_t                   page_pool[POOL_SIZE];

    lru_order_checker tracker_model = new();

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lru_page_replacement_tracker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The result side stalls at random, at whatever rate the current phase
    // of the run asks for. A rate of zero keeps the block's output free.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Both handshakes are sampled here, on values that settled before the
    // edge. A result accepted at this edge always comes from an earlier
    // request, so the order of the two calls does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                tracker_model.check_result('{
                    status:       m_axis_tuser[lprt_pkg::STATUS_W-1:0],
                    cand_page:    m_axis_tdata[lprt_pkg::PAGE_BITS-1:0],
                    victim_valid: m_axis_tuser[lprt_pkg::STATUS_W],
                    victim_rank:  m_axis_tdata[lprt_pkg::PAGE_BITS +: lprt_pkg::RANK_W],
                    last:         m_axis_tlast});
            if (s_axis_tvalid && s_axis_tready)
                tracker_model.note_request(s_axis_tuser,
                                           s_axis_tdata[lprt_pkg::PAGE_BITS-1:0]);
        end
    end

    // Guard against a hung block.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. It is entered at a rising edge and returns at the edge
    // where its request was accepted, without having scheduled anything for
    // that edge. So a back-to-back request keeps tvalid high with a single
    // assignment, and an idle gap lowers it with a single assignment.
    // ------------------------------------------------------------------------
    task automatic drive_request(logic [lprt_pkg::OP_W-1:0] op, page_t page);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= page;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // The sender goes quiet until every predicted result has come back. The
    // task always waits on the clock first, so that tvalid is never lowered and
    // raised in the same step.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker_model.pending_outcomes.size() != 0);
    endtask

    // Most pages come from a fixed pool somewhat larger than the tracker, so
    // hits, misses, removals and full drops all occur often. A tenth of the
    // pages are fully random and nearly always miss.
    task automatic random_request(int access_pct, int evict_pct, int victim_pct);
        int                          r;
        logic [lprt_pkg::OP_W-1:0]   op;
        page_t                       pg;
        r = $urandom_range(0, 99);
        if (r < access_pct)
            op = lprt_pkg::OP_ACCESS;
        else if (r < access_pct + evict_pct)
            op = lprt_pkg::OP_EVICTED;
        else if (r < access_pct + evict_pct + victim_pct)
            op = lprt_pkg::OP_REQUEST;
        else
            op = OP_UNUSED;
        if ($urandom_range(0, 9) == 0)
            pg = {8'($urandom), 32'($urandom)};
        else
            pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
        drive_request(op, pg);
    endtask

    initial
    begin
        // Pool pages carry their index in the low bits so they are distinct;
        // the upper bits are random so every page bit toggles.
        for (int i = 0; i < POOL_SIZE; i++)
            page_pool[i] = {8'($urandom), 25'($urandom), 7'(i)};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side. It opens on an empty
        // tracker, walks through hits, inserts, removals, an ignored code,
        // the page extremes, and a victim list cut short at the list limit.
        drive_request(lprt_pkg::OP_REQUEST, '0);
        drive_request(lprt_pkg::OP_EVICTED, '0);
        drive_request(lprt_pkg::OP_ACCESS, '0);
        drive_request(lprt_pkg::OP_ACCESS, '1);
        drive_request(lprt_pkg::OP_ACCESS, '0);
        drive_request(OP_UNUSED, '1);
        drive_request(lprt_pkg::OP_REQUEST, '1);
        drive_request(lprt_pkg::OP_EVICTED, '1);
        drive_request(lprt_pkg::OP_EVICTED, '0);
        drive_request(lprt_pkg::OP_REQUEST, '0);
        for (int i = 0; i < 9; i++)
            drive_request(lprt_pkg::OP_ACCESS, page_pool[i]);
        // The oldest page becomes the newest, so the victim order rotates.
        drive_request(lprt_pkg::OP_ACCESS, page_pool[0]);
        drive_request(lprt_pkg::OP_REQUEST, '0);
        drive_request(lprt_pkg::OP_EVICTED, page_pool[4]);
        drive_request(lprt_pkg::OP_REQUEST, '0);
        wait_for_results();

        // Sender idle most of the time. A burst of distinct accesses fills
        // the tracker past capacity, so full drops follow.
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        for (int i = 0; i < 70; i++)
            drive_request(lprt_pkg::OP_ACCESS, page_pool[i]);
        for (int i = 0; i < 50; i++)
            random_request(70, 12, 14);
        wait_for_results();

        // Result side stalling most of the time; removals dominate, so the
        // tracker drains and refills.
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        for (int i = 0; i < 90; i++)
            random_request(30, 50, 15);
        wait_for_results();

        // Light idling on both sides, access heavy.
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        for (int i = 0; i < 90; i++)
            random_request(65, 20, 12);
        wait_for_results();

        // Back to full rate on both sides with a balanced mix.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 70; i++)
            random_request(50, 32, 14);
        wait_for_results();

        // An ignored code gives no result, so allow a full victim pass to end
        // before looking for stray output.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker_model.mismatches == 0 && tracker_model.pending_outcomes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/lprt_pkg.sv
hdl/lprt_cell.sv
hdl/lprt_enc.sv
hdl/lru_page_replacement_tracker_unit.sv
tb/sv/lru_page_replacement_tracker_unit_tb.sv
